// ===== hw/rtl/dcbp_pkg.sv =====
// Shared types and constants of the delta channel bit packer.
// No dependencies; every other file of the block except dcbp_stream_if refers to this package.

package dcbp_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SCALE       = 2'd0,
    REG_KEY_MASK    = 2'd1,
    REG_FRAME_COUNT = 2'd2
  } cfg_reg_t;

  localparam int unsigned SCALE_W     = 25;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned PRODUCT_W   = SAMPLE_W + SCALE_W;
  localparam int unsigned ROUNDED_W   = 33;
  localparam int unsigned FRAC_W      = 24;
  localparam int unsigned KEY_W       = 16;
  localparam int unsigned FRAMES_W    = 13;
  localparam int unsigned WORD_W      = 15;
  localparam int unsigned MAX_FRAMES  = 4096;
  localparam int unsigned MIN_FRAMES  = 2;

  localparam logic signed [SCALE_W-1:0] SCALE_RESET      = 25'sd65536;
  localparam logic [KEY_W-1:0]          KEY_MASK_RESET   = 16'hFFFF;
  localparam logic [FRAMES_W-1:0]       FRAMES_RESET     = 13'd2;
  localparam logic [WORD_W-1:0]         HEADER_TAG       = 15'h0020;

  // Byte queue between the packer and the output channel.
  localparam int unsigned BURST_MAX   = 8;
  localparam int unsigned BURST_CNT_W = $clog2(BURST_MAX + 1);
  localparam int unsigned FIFO_DEPTH  = 16;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_LVL_W  = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [ROUNDED_W-1:0] rounded_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                channel_end;
    logic [KEY_W-1:0]    key;
    logic [FRAMES_W-1:0] value_count;
  } byte_item_t;

  // All bytes produced by one sample, written to the queue in the same cycle.
  typedef struct packed {
    logic                   write;
    logic [BURST_CNT_W-1:0] count;
    byte_item_t [BURST_MAX-1:0] items;
  } byte_burst_t;

endpackage

// ===== hw/rtl/dcbp_stream_if.sv =====
// Valid/ready stream channel used on the sample, rounded and byte paths of the packer.
// Depends on nothing; the payload type is given per instance.

interface dcbp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/delta_channel_bit_packer.sv =====
// Top level of the delta channel bit packer: configuration registers, scaler,
// packer and byte queue. Depends on dcbp_pkg, dcbp_stream_if and all dcbp modules.

// Samples enter on "samples" and packed bytes leave on "packed_bytes", one byte
// per transfer; the last padding byte of a channel carries channel_end, key and
// value_count. A sample can be taken in every cycle unless the scaler is held by
// the packer: it passes the scaler's input register, multiply and rounding
// registers and is then packed into the byte queue as one burst. The sustained
// rate is set by the output side, which gives one byte a cycle while
// packed_bytes is ready: a sample produces one or two bytes for a plain delta,
// up to four with a group header and up to eight when it closes the channel.
// The packer waits while the queue has fewer than eight free places.
// Configuration may be written only while the block is idle.

module delta_channel_bit_packer #(
  parameter int unsigned GROUP_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [dcbp_pkg::SCALE_W-1:0]   cfg_data,
  dcbp_stream_if.sink                    samples,
  dcbp_stream_if.source                  packed_bytes
);

  logic signed [dcbp_pkg::SCALE_W-1:0]  scale;
  logic [dcbp_pkg::KEY_W-1:0]           key_mask;
  logic [dcbp_pkg::FRAMES_W-1:0]        frame_count;
  logic [dcbp_pkg::FIFO_LVL_W-1:0]      level;
  dcbp_pkg::byte_burst_t                burst;

  dcbp_stream_if #(.payload_t(dcbp_pkg::rounded_t)) rounded ();

  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= dcbp_pkg::SCALE_RESET;
      key_mask    <= dcbp_pkg::KEY_MASK_RESET;
      frame_count <= dcbp_pkg::FRAMES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcbp_pkg::REG_SCALE:       scale       <= $signed(cfg_data);
        dcbp_pkg::REG_KEY_MASK:    key_mask    <= cfg_data[dcbp_pkg::KEY_W-1:0];
        dcbp_pkg::REG_FRAME_COUNT: frame_count <= cfg_data[dcbp_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  dcbp_scaler u_scaler (
    .clk     (clk),
    .rst     (rst),
    .scale   (scale),
    .samples (samples),
    .rounded (rounded)
  );

  dcbp_packer #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_packer (
    .clk         (clk),
    .rst         (rst),
    .key_mask    (key_mask),
    .frame_count (frame_count),
    .level       (level),
    .rounded     (rounded),
    .burst       (burst)
  );

  dcbp_byte_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .burst        (burst),
    .level        (level),
    .packed_bytes (packed_bytes)
  );

`ifndef NO_ASSERTIONS
  // A burst must always fit into the free part of the queue.
  a_burst_fits: assert property (@(posedge clk) disable iff (rst)
    burst.write |-> (32'(level) + 32'(burst.count)) <= dcbp_pkg::FIFO_DEPTH)
    else $error("byte burst overflows the queue");

  a_burst_count: assert property (@(posedge clk) disable iff (rst)
    burst.write |-> 32'(burst.count) <= dcbp_pkg::BURST_MAX)
    else $error("byte burst longer than the maximum");

  // The channel always closes on a zero padding byte.
  a_end_is_pad: assert property (@(posedge clk) disable iff (rst)
    (packed_bytes.valid && packed_bytes.payload.channel_end)
      |-> packed_bytes.payload.out_byte == 8'd0)
    else $error("channel end marked on a data byte");

  // Each transfer out of the queue lowers its level unless a burst arrives.
  a_level_drops: assert property (@(posedge clk) disable iff (rst)
    (packed_bytes.valid && packed_bytes.ready && !burst.write)
      |=> level == $past(level) - dcbp_pkg::FIFO_LVL_W'(1))
    else $error("queue level not updated on transfer");
`endif

endmodule

// ===== hw/rtl/dcbp_scaler.sv =====
// Sample scaler: input register, registered multiply, registered rounding.
// Depends on dcbp_pkg and dcbp_stream_if.

module dcbp_scaler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [dcbp_pkg::SCALE_W-1:0]   scale,
  dcbp_stream_if.sink                           samples,
  dcbp_stream_if.source                         rounded
);

  localparam int unsigned PW = dcbp_pkg::PRODUCT_W;
  localparam int unsigned RW = dcbp_pkg::ROUNDED_W;
  localparam int unsigned FW = dcbp_pkg::FRAC_W;

  logic                                   s1_valid;
  logic signed [dcbp_pkg::SAMPLE_W-1:0]   s1_sample;
  logic                                   s2_valid;
  logic signed [PW-1:0]                   s2_product;
  logic                                   s3_valid;
  dcbp_pkg::rounded_t                     s3_value;

  logic s1_ready, s2_ready, s3_ready;

  logic [PW-1:0]      mag;
  logic [PW-1:0]      mag_rounded;
  logic [RW-1:0]      rmag;
  dcbp_pkg::rounded_t value_next;

  assign s3_ready = !s3_valid || rounded.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign samples.ready   = s1_ready;
  assign rounded.valid   = s3_valid;
  assign rounded.payload = s3_value;

  // Round half away from zero: round the magnitude, then restore the sign.
  always_comb begin
    mag         = s2_product[PW-1] ? PW'(-s2_product) : PW'(s2_product);
    mag_rounded = mag + (PW'(1) << (FW - 1));
    rmag        = mag_rounded[FW +: RW];
    value_next  = s2_product[PW-1] ? -$signed(rmag) : $signed(rmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= samples.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && samples.valid) begin
      s1_sample <= samples.payload.sample;
    end
    if (s2_ready && s1_valid) begin
      s2_product <= PW'(s1_sample) * PW'(scale);
    end
    if (s3_ready && s2_valid) begin
      s3_value <= value_next;
    end
  end

endmodule

// ===== hw/rtl/dcbp_packer.sv =====
// Delta, header and bit packing stage: turns one rounded sample into a burst
// of up to eight bytes. Depends on dcbp_pkg and dcbp_stream_if.

module dcbp_packer #(
  parameter int unsigned GROUP_SIZE = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [dcbp_pkg::KEY_W-1:0]            key_mask,
  input  logic [dcbp_pkg::FRAMES_W-1:0]         frame_count,
  input  logic [dcbp_pkg::FIFO_LVL_W-1:0]       level,
  dcbp_stream_if.sink                           rounded,
  output dcbp_pkg::byte_burst_t                 burst
);

  localparam int unsigned FRW = dcbp_pkg::FRAMES_W;
  localparam int unsigned WW  = dcbp_pkg::WORD_W;
  localparam int unsigned RW  = dcbp_pkg::ROUNDED_W;
  localparam int unsigned CW  = dcbp_pkg::BURST_CNT_W;
  localparam int unsigned GW  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int unsigned LW  = dcbp_pkg::FIFO_LVL_W;

  localparam logic signed [RW:0] DELTA_HIGH = (RW + 1)'(16383);
  localparam logic signed [RW:0] DELTA_LOW  = -(RW + 1)'(16384);

  logic [FRW-1:0]            sample_index;
  dcbp_pkg::rounded_t        previous_rounded;
  logic [FRW-1:0]            word_counter;
  logic [7:0]                pending_bits;
  logic [2:0]                pending_fill;
  logic [dcbp_pkg::KEY_W-1:0] held_key;
  logic [GW-1:0]             group_pos;

  logic                      fire;
  logic                      first;
  logic                      last;
  logic                      header;
  logic [FRW-1:0]            frames;
  logic [FRW-1:0]            remaining;
  logic [WW-1:0]             header_word;
  logic signed [RW:0]        diff;
  logic [WW-1:0]             delta_word;
  logic [2*WW-1:0]           words;
  logic [63:0]               stream;
  logic [63:0]               stream_rest;
  logic [5:0]                nbits;
  logic [2:0]                nbytes;
  logic [FRW-1:0]            word_counter_next;
  logic [CW:0]               total;
  logic [CW-1:0]             emit_count;

  assign rounded.ready = level <= LW'(dcbp_pkg::FIFO_DEPTH - dcbp_pkg::BURST_MAX);
  assign fire          = rounded.valid && rounded.ready;

  always_comb begin
    if (frame_count < FRW'(dcbp_pkg::MIN_FRAMES)) begin
      frames = FRW'(dcbp_pkg::MIN_FRAMES);
    end else if (frame_count > FRW'(dcbp_pkg::MAX_FRAMES)) begin
      frames = FRW'(dcbp_pkg::MAX_FRAMES);
    end else begin
      frames = frame_count;
    end

    first  = sample_index == '0;
    header = group_pos == '0;
    last   = ({1'b0, sample_index} + (FRW + 1)'(1)) >= {1'b0, frames};

    // A header counts the samples still to come when fewer than a group remain.
    remaining = (frames > sample_index) ? frames - sample_index : '0;
    if (remaining < FRW'(GROUP_SIZE)) begin
      header_word = dcbp_pkg::HEADER_TAG | WW'(remaining[3:0]);
    end else begin
      header_word = dcbp_pkg::HEADER_TAG;
    end

    diff = $signed({rounded.payload[RW-1], rounded.payload})
         - $signed({previous_rounded[RW-1], previous_rounded});
    if (diff > DELTA_HIGH) begin
      delta_word = WW'(16383);
    end else if (diff < DELTA_LOW) begin
      delta_word = 15'h4000;
    end else begin
      delta_word = diff[WW-1:0];
    end

    if (header) begin
      words = {delta_word, header_word};
      nbits = 6'(pending_fill) + 6'(2 * WW);
      word_counter_next = word_counter + FRW'(2);
    end else begin
      words = {{WW{1'b0}}, delta_word};
      nbits = 6'(pending_fill) + 6'(WW);
      word_counter_next = word_counter + FRW'(1);
    end

    stream      = {56'd0, pending_bits} | (64'(words) << pending_fill);
    nbytes      = nbits[5:3];
    stream_rest = stream >> {nbytes, 3'b000};

    // At the channel end: flush the partial byte, then three or four zero bytes.
    total = (CW + 1)'(nbytes);
    if (last) begin
      total = total + (CW + 1)'(nbits[2:0] != 3'd0)
            + ((word_counter_next[2:0] == 3'd0) ? (CW + 1)'(4) : (CW + 1)'(3));
    end
    if (total > (CW + 1)'(dcbp_pkg::BURST_MAX)) begin
      emit_count = CW'(dcbp_pkg::BURST_MAX);
    end else begin
      emit_count = total[CW-1:0];
    end

    burst.write = fire;
    burst.count = first ? '0 : emit_count;
    for (int k = 0; k < dcbp_pkg::BURST_MAX; k++) begin
      burst.items[k].out_byte    = stream[8*k +: 8];
      burst.items[k].channel_end = 1'b0;
      burst.items[k].key         = '0;
      burst.items[k].value_count = '0;
      if (last && (CW'(k) == emit_count - CW'(1))) begin
        burst.items[k].channel_end = 1'b1;
        burst.items[k].key         = held_key & key_mask;
        burst.items[k].value_count = word_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index     <= '0;
      previous_rounded <= '0;
      word_counter     <= '0;
      pending_bits     <= '0;
      pending_fill     <= '0;
      held_key         <= '0;
      group_pos        <= '0;
    end else if (fire) begin
      if (first) begin
        sample_index     <= FRW'(1);
        previous_rounded <= rounded.payload;
        held_key         <= rounded.payload[dcbp_pkg::KEY_W-1:0];
        group_pos        <= '0;
      end else if (last) begin
        sample_index     <= '0;
        previous_rounded <= '0;
        word_counter     <= '0;
        pending_bits     <= '0;
        pending_fill     <= '0;
        held_key         <= '0;
        group_pos        <= '0;
      end else begin
        sample_index     <= sample_index + FRW'(1);
        previous_rounded <= rounded.payload;
        word_counter     <= word_counter_next;
        pending_bits     <= stream_rest[7:0];
        pending_fill     <= nbits[2:0];
        group_pos        <= (group_pos == GW'(GROUP_SIZE - 1)) ? '0 : group_pos + GW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/dcbp_byte_fifo.sv =====
// Byte queue: takes a burst of up to eight bytes a cycle, gives one a cycle while ready.
// Depends on dcbp_pkg and dcbp_stream_if.

module dcbp_byte_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  dcbp_pkg::byte_burst_t            burst,
  output logic [dcbp_pkg::FIFO_LVL_W-1:0]  level,
  dcbp_stream_if.source                    packed_bytes
);

  localparam int unsigned PTRW = dcbp_pkg::FIFO_PTR_W;
  localparam int unsigned LW   = dcbp_pkg::FIFO_LVL_W;

  dcbp_pkg::byte_item_t mem [dcbp_pkg::FIFO_DEPTH];
  logic [PTRW-1:0]      head;
  logic [PTRW-1:0]      tail;
  logic                 pop;
  logic [LW-1:0]        pushed;

  assign tail                 = head + level[PTRW-1:0];
  assign pop                  = packed_bytes.valid && packed_bytes.ready;
  assign pushed               = burst.write ? LW'(burst.count) : '0;
  assign packed_bytes.valid   = level != '0;
  assign packed_bytes.payload = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      level <= '0;
    end else begin
      if (pop) begin
        head <= head + PTRW'(1);
      end
      level <= level + pushed - LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < dcbp_pkg::BURST_MAX; k++) begin
      if (burst.write && (dcbp_pkg::BURST_CNT_W'(k) < burst.count)) begin
        mem[tail + PTRW'(k)] <= burst.items[k];
      end
    end
  end

endmodule

// ===== verif/tb_delta_channel_bit_packer.sv =====
// Self-checking testbench for delta_channel_bit_packer: directed rows, then random channels.
// Depends on dcbp_pkg, dcbp_stream_if and the block's RTL; a local predictor gives every byte not typed into the plan.

module tb_delta_channel_bit_packer;

  localparam int unsigned GROUP_LEN     = 16;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 100;
  // Index beyond the register list; the block must ignore writes to it.
  localparam logic [1:0]  REG_SPARE     = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [31:0] value;
    int          typed_n;      // bytes typed in below, or -1 to use the predictor
    logic [63:0] typed_bytes;  // first byte in the low eight bits
    logic [15:0] typed_key;
    logic [12:0] typed_count;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [dcbp_pkg::SCALE_W-1:0] cfg_data;

  dcbp_stream_if #(.payload_t(dcbp_pkg::sample_item_t)) samples_if ();
  dcbp_stream_if #(.payload_t(dcbp_pkg::byte_item_t))   bytes_if ();

  delta_channel_bit_packer #(.GROUP_SIZE(GROUP_LEN)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .samples      (samples_if),
    .packed_bytes (bytes_if)
  );

  // Predictor copy of the registers and of the per-channel state.
  logic signed [dcbp_pkg::SCALE_W-1:0] m_scale;
  logic [dcbp_pkg::KEY_W-1:0]          m_mask;
  logic [dcbp_pkg::FRAMES_W-1:0]       m_frames;
  int unsigned                         st_index;
  longint                              st_prev;
  int unsigned                         st_words;
  logic [7:0]                          st_bits;
  int unsigned                         st_fill;
  logic [dcbp_pkg::KEY_W-1:0]          st_key;

  dcbp_pkg::byte_item_t  fresh[$];
  dcbp_pkg::byte_item_t  bytes_due[$];
  dcbp_pkg::byte_item_t  want;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned hold_req;
  int unsigned hold_seen;

  plan_row_t   plan [32];
  int unsigned k;
  int unsigned n;
  int unsigned j;
  int unsigned len;
  int unsigned rand_count;
  int unsigned rand_sent;
  logic [31:0] cur;
  dcbp_pkg::byte_item_t  typed;
  bit          held;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint scaled_round(logic [31:0] raw,
                                          logic signed [dcbp_pkg::SCALE_W-1:0] m);
    longint p;
    longint mag;
    p = longint'(signed'(raw)) * longint'(m);
    mag = (p < 0) ? -p : p;
    mag = (mag + 64'sd8388608) >> dcbp_pkg::FRAC_W;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic int unsigned live_frames();
    int unsigned f;
    f = m_frames;
    if (f < dcbp_pkg::MIN_FRAMES) f = dcbp_pkg::MIN_FRAMES;
    if (f > dcbp_pkg::MAX_FRAMES) f = dcbp_pkg::MAX_FRAMES;
    return f;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    dcbp_pkg::byte_item_t it;
    it = '0;
    it.out_byte = b;
    fresh.push_back(it);
  endfunction

  // Words go out least significant bit first behind the unfinished byte.
  function automatic void push_word(logic [dcbp_pkg::WORD_W-1:0] w);
    logic [23:0] acc;
    int unsigned nbits;
    acc = {16'b0, st_bits} | (24'(w) << st_fill);
    nbits = st_fill + dcbp_pkg::WORD_W;
    while (nbits >= 8) begin
      put_byte(acc[7:0]);
      acc = acc >> 8;
      nbits -= 8;
    end
    st_bits = acc[7:0];
    st_fill = nbits;
    st_words++;
  endfunction

  function automatic void pack_sample(logic [31:0] raw);
    longint r;
    longint d;
    int unsigned frames;
    int unsigned rem;
    int unsigned pads;
    int unsigned i;
    dcbp_pkg::byte_item_t last;
    fresh.delete();
    frames = live_frames();
    r = scaled_round(raw, m_scale);
    if (st_index == 0) begin
      st_key = r[15:0];
      st_prev = r;
      st_index = 1;
    end else begin
      i = st_index;
      if ((i - 1) % GROUP_LEN == 0) begin
        rem = (frames > i) ? frames - i : 0;
        if (rem >= GROUP_LEN) rem = 0;
        push_word(dcbp_pkg::HEADER_TAG | 15'(rem));
      end
      d = r - st_prev;
      if (d > 16383) d = 16383;
      else if (d < -16384) d = -16384;
      push_word(d[14:0]);
      st_prev = r;
      if (i + 1 >= frames) begin
        if (st_fill != 0) put_byte(st_bits);
        pads = (st_words % 8 == 0) ? 4 : 3;
        repeat (pads) put_byte(8'h00);
        // One sample gives at most a burst of bytes; the end mark goes on the last kept.
        while (fresh.size() > int'(dcbp_pkg::BURST_MAX)) void'(fresh.pop_back());
        last = fresh[fresh.size() - 1];
        last.channel_end = 1'b1;
        last.key = st_key & m_mask;
        last.value_count = 13'(st_words);
        fresh[fresh.size() - 1] = last;
        st_index = 0;
        st_prev = 0;
        st_words = 0;
        st_bits = '0;
        st_fill = 0;
        st_key = '0;
      end else begin
        st_index = i + 1;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && bytes_if.valid && bytes_if.ready) begin
      if (bytes_due.size() == 0) begin
        $display("%0t: byte with none expected, got byte %h end %b key %h count %h",
                 $time, bytes_if.payload.out_byte, bytes_if.payload.channel_end,
                 bytes_if.payload.key, bytes_if.payload.value_count);
        mismatches++;
      end else begin
        want = bytes_due.pop_front();
        check_field("out_byte", 16'(want.out_byte), 16'(bytes_if.payload.out_byte));
        check_field("channel_end", 16'(want.channel_end), 16'(bytes_if.payload.channel_end));
        check_field("key", want.key, bytes_if.payload.key);
        check_field("value_count", 16'(want.value_count), 16'(bytes_if.payload.value_count));
      end
    end
  end

  // Output side: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin
    bytes_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        bytes_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        bytes_if.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Returns at the edge of the transfer with valid still high, so that a following
  // sample can be offered straight away.
  task automatic put_sample(input logic [31:0] s);
    if ($urandom_range(99) < send_idle) begin
      samples_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    samples_if.valid <= 1'b1;
    samples_if.payload.sample <= s;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  task automatic feed(input logic [31:0] s);
    put_sample(s);
    pack_sample(s);
    foreach (fresh[q]) bytes_due.push_back(fresh[q]);
  endtask

  // Random samples move through the idling phases in steps of 25 transfers.
  task automatic random_feed(input logic [31:0] s);
    case ((rand_sent / 25) % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 68; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 68; end
      default: begin send_idle = 9; recv_stall = 9; end
    endcase
    rand_sent++;
    feed(s);
  endtask

  task automatic drain_bytes();
    samples_if.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[dcbp_pkg::SCALE_W-1:0];
    @(posedge clk);
    case (idx)
      dcbp_pkg::REG_SCALE:       m_scale = val[dcbp_pkg::SCALE_W-1:0];
      dcbp_pkg::REG_KEY_MASK:    m_mask = val[dcbp_pkg::KEY_W-1:0];
      dcbp_pkg::REG_FRAME_COUNT: m_frames = val[dcbp_pkg::FRAMES_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(3))
      0: return 32'h0001_0000;
      1: return $urandom_range(1 << 18);
      2: return -$urandom_range(1 << 18);
      default: return $urandom;
    endcase
  endfunction

  // Mostly a walk with deltas that stay clear of saturation, some extremes and noise.
  function automatic logic [31:0] next_sample(logic [31:0] last);
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return last + $urandom_range(1 << 20) - (1 << 19);
    endcase
  endfunction

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= dcbp_pkg::REG_SCALE;
    cfg_data <= '0;
    samples_if.valid <= 1'b0;
    samples_if.payload <= '0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 0;
    rand_sent = 0;
    held = 1'b0;
    m_scale = dcbp_pkg::SCALE_RESET;
    m_mask = dcbp_pkg::KEY_MASK_RESET;
    m_frames = dcbp_pkg::FRAMES_RESET;
    st_index = 0;
    st_prev = 0;
    st_words = 0;
    st_bits = '0;
    st_fill = 0;
    st_key = '0;

    // Two typed channels: one plus three, and minus a half plus a half, which round
    // away from zero to -1 and +1. Both give header 0x21 and a delta of two.
    plan = '{
      '{ROW_SAMPLE, REG_SPARE,                 32'h0000_0100, 0, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h0000_0300, 7, 64'h0000_0000_0001_0021,
        16'h0001, 13'd2},
      '{ROW_REG,    REG_SPARE,                 32'h01AB_CDEF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_SCALE,       32'h00FF_FFFF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_FRAME_COUNT, 32'h0000_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h7FFF_FFFF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h8000_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_SCALE,       32'h0100_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_KEY_MASK,    32'h0000_00FF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_FRAME_COUNT, 32'h0000_0001, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h8000_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h7FFF_FFFF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h7FFF_FFFF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h8000_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_SCALE,       32'h0001_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_KEY_MASK,    32'h0000_FFFF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_FRAME_COUNT, 32'h0000_0002, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'hFFFF_FF80, 0, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h0000_0080, 7, 64'h0000_0000_0001_0021,
        16'hFFFF, 13'd2},
      '{ROW_REG,    dcbp_pkg::REG_FRAME_COUNT, 32'h0000_1FFF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h0000_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h0000_0100, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h0000_0200, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_FRAME_COUNT, 32'h0000_0003, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'hFFFF_FF00, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_FRAME_COUNT, 32'h0000_1FFF, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h1234_5678, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'hEDCB_A988, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_SCALE,       32'h0000_0100, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_KEY_MASK,    32'h0000_0000, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_REG,    dcbp_pkg::REG_FRAME_COUNT, 32'h0000_0002, -1, 64'h0, 16'h0, 13'd0},
      '{ROW_SAMPLE, REG_SPARE,                 32'h0000_0180, -1, 64'h0, 16'h0, 13'd0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers change only once the block has gone quiet, mid-channel included.
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        drain_bytes();
        write_reg(plan[r].index, plan[r].value);
      end else if (plan[r].typed_n < 0) begin
        feed(plan[r].value);
      end else begin
        put_sample(plan[r].value);
        pack_sample(plan[r].value);
        for (k = 0; k < plan[r].typed_n; k++) begin
          typed = '0;
          typed.out_byte = plan[r].typed_bytes[8*k +: 8];
          if (k == plan[r].typed_n - 1) begin
            typed.channel_end = 1'b1;
            typed.key = plan[r].typed_key;
            typed.value_count = plan[r].typed_count;
          end
          bytes_due.push_back(typed);
        end
      end
    end

    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      cur = $urandom;
      if (!held || $urandom_range(5) == 0) begin
        // Frame count lowered under a long channel, so the next sample closes it.
        drain_bytes();
        write_reg(dcbp_pkg::REG_SCALE, rand_scale());
        write_reg(dcbp_pkg::REG_FRAME_COUNT,
                  $urandom_range(1) ? dcbp_pkg::MAX_FRAMES : $urandom_range(4097, 8191));
        len = $urandom_range(1) ? 17 : $urandom_range(2, 40);
        // The first such channel also holds off the output while samples keep coming.
        if (!held) begin
          held = 1'b1;
          len = 40;
          hold_req++;
        end
        for (j = 0; j < len; j++) begin
          cur = next_sample(cur);
          random_feed(cur);
        end
        drain_bytes();
        write_reg(dcbp_pkg::REG_FRAME_COUNT, $urandom_range(len));
        random_feed(next_sample(cur));
        rand_count += len + 1;
      end else begin
        if ($urandom_range(1)) begin
          drain_bytes();
          write_reg(dcbp_pkg::REG_SCALE, rand_scale());
          write_reg(dcbp_pkg::REG_KEY_MASK, $urandom);
          if ($urandom_range(9) == 0) n = $urandom_range(1);
          else if ($urandom_range(3) == 0) n = $urandom_range(17, 40);
          else n = $urandom_range(2, 12);
          write_reg(dcbp_pkg::REG_FRAME_COUNT, n);
        end
        len = live_frames();
        for (j = 0; j < len; j++) begin
          // Now and then the sender waits for every byte and the scale changes.
          if (j == len / 2 && j > 0 && $urandom_range(7) == 0) begin
            drain_bytes();
            write_reg(dcbp_pkg::REG_SCALE, rand_scale());
          end
          cur = next_sample(cur);
          random_feed(cur);
        end
        rand_count += len;
      end
    end

    samples_if.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== delta_channel_bit_packer.f =====
hw/rtl/dcbp_pkg.sv
hw/rtl/dcbp_stream_if.sv
hw/rtl/dcbp_scaler.sv
hw/rtl/dcbp_packer.sv
hw/rtl/dcbp_byte_fifo.sv
hw/rtl/delta_channel_bit_packer.sv
verif/tb_delta_channel_bit_packer.sv
